/* rtl/cwd_pkg.sv */
package cwd_pkg;

  // Column store geometry
  localparam int MAX_COLS = 32;
  localparam int IDX_W    = $clog2(MAX_COLS);
  localparam int CNT_W    = IDX_W + 1;

  // Field widths
  localparam int FIELD_W  = 12;
  localparam int AVAIL_W  = 16;
  localparam int COLIDX_W = 5;
  localparam int WID_W    = 17;
  localparam int TOT_W    = FIELD_W + IDX_W;

  // Flex product and divider widths
  localparam int FLEX_W   = FIELD_W + 1;
  localparam int PROD_W   = AVAIL_W + FLEX_W + 1;
  localparam int DVD_W    = PROD_W - 1;
  localparam int DVS_W    = TOT_W;
  localparam int QUO_W    = AVAIL_W;
  localparam int STEP_W   = $clog2(QUO_W + 1);

  // Quotient bits per division: full run for the slack share, short run for
  // the flex share, whose quotient is known to stay below 2**FIELD_W
  localparam int FULL_STEPS  = QUO_W;
  localparam int SHORT_STEPS = FIELD_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SETUP,
    S_PDIV,
    S_RD,
    S_MUL,
    S_QSTART,
    S_QWAIT,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_FIT,
    MODE_MIN,
    MODE_FLEX
  } mode_t;

  typedef struct packed {
    logic               start;
    logic               short_q;
    logic [DVD_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [QUO_W-1:0]   quot;
    logic [DVS_W-1:0]   rem;
  } div_rsp_t;

endpackage

/* rtl/cwd_store.sv */
module cwd_store
  import cwd_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [FIELD_W-1:0] wr_pref,
  input  logic [FIELD_W-1:0] wr_min,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [FIELD_W-1:0] rd_pref,
  output logic [FIELD_W-1:0] rd_min
);

  logic [FIELD_W-1:0] pref_mem [MAX_COLS];
  logic [FIELD_W-1:0] min_mem  [MAX_COLS];
  logic [FIELD_W-1:0] rd_pref_r;
  logic [FIELD_W-1:0] rd_min_r;

  // Write one column, read one column with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pref_mem[wr_addr] <= wr_pref;
      min_mem[wr_addr]  <= wr_min;
    end
    rd_pref_r <= pref_mem[rd_addr];
    rd_min_r  <= min_mem[rd_addr];
  end

  assign rd_pref = rd_pref_r;
  assign rd_min  = rd_min_r;

endmodule

/* rtl/cwd_div.sv */
module cwd_div
  import cwd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVS_W-1:0]  rem_r,  rem_nxt;
  logic [QUO_W-1:0]  quo_r,  quo_nxt;
  logic [DVS_W-1:0]  dvs_r,  dvs_nxt;
  logic [STEP_W-1:0] cnt_r,  cnt_nxt;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  // One restoring step per cycle: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, quo_r[QUO_W-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    if (req.start) begin
      dvs_nxt = req.divisor;
      if (req.short_q) begin
        rem_nxt = DVS_W'(req.dividend[DVD_W-1:SHORT_STEPS]);
        quo_nxt = {req.dividend[SHORT_STEPS-1:0], (QUO_W-SHORT_STEPS)'(0)};
        cnt_nxt = STEP_W'(SHORT_STEPS);
      end else begin
        rem_nxt = '0;
        quo_nxt = req.dividend[QUO_W-1:0];
        cnt_nxt = STEP_W'(FULL_STEPS);
      end
    end else if (cnt_r != '0) begin
      rem_nxt = fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = cnt_r != '0;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

/* rtl/column_width_distributor.sv */
// Column width distributor: one input word per column, widths out after the last column.
// Non-last words are taken back to back. Fit runs divide the slack once on the bit-serial
// divider; minimum runs do not divide; flex runs divide on it for every column but the
// last (12 quotient bits per column), and the last column takes the width left over.
// No new input is taken until the last width of a run is delivered.
// rst_n is synchronous, active low; it clears the sequencer, counters and totals.
module column_width_distributor
  import cwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [11:0] pref_width, [23:12] min_width, [39:24] avail_width
  input  logic        in_tlast,   // last_column
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [4:0] col_index, [21:5] col_width, [23:22] zero
  output logic        out_tlast   // last_result
);

  state_t state_r, state_nxt;
  mode_t  mode_r,  mode_nxt;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TOT_W-1:0]    ptot_r,  ptot_nxt;
  logic [TOT_W-1:0]    mtot_r,  mtot_nxt;
  logic [AVAIL_W-1:0]  avail_r, avail_nxt;
  logic [IDX_W-1:0]    idx_r,   idx_nxt;
  logic [AVAIL_W-1:0]  span_r,  span_nxt;
  logic [TOT_W-1:0]    tflex_r, tflex_nxt;
  logic [QUO_W-1:0]    per_r,   per_nxt;
  logic [IDX_W-1:0]    prem_r,  prem_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [TOT_W-1:0]    asum_r,  asum_nxt;
  logic [COLIDX_W-1:0] oidx_r,  oidx_nxt;
  logic [WID_W-1:0]    owid_r,  owid_nxt;
  logic                olast_r, olast_nxt;

  logic [FIELD_W-1:0]  in_pref;
  logic [FIELD_W-1:0]  in_min;
  logic [AVAIL_W-1:0]  in_avail;
  logic                in_acc;
  logic                out_acc;
  logic                store_room;
  logic                wr_en;
  logic [FIELD_W-1:0]  rd_pref;
  logic [FIELD_W-1:0]  rd_min;
  logic                col_last;
  logic                fit_all;
  logic                min_over;
  logic [TOT_W:0]      avail_ext;
  logic signed [FLEX_W-1:0]  flex;
  logic signed [PROD_W-1:0]  prod_mag;
  logic signed [WID_W:0]     flex_add;
  logic signed [WID_W:0]     flex_wid;
  logic [WID_W:0]            tail_wid;
  div_req_t            dreq;
  div_rsp_t            drsp;

  assign in_pref  = in_tdata[11:0];
  assign in_min   = in_tdata[23:12];
  assign in_avail = in_tdata[39:24];
  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;

  assign store_room = count_r < CNT_W'(MAX_COLS);
  assign wr_en      = in_acc && store_room;
  assign col_last   = ({1'b0, idx_r} == (count_r - 1'b1));

  // Pick the distribution case from the totals
  assign avail_ext = (TOT_W+1)'(avail_r);
  assign fit_all   = {1'b0, ptot_r} <= avail_ext;
  assign min_over  = {1'b0, mtot_r} >= avail_ext;

  // Flex share arithmetic
  assign flex     = $signed({1'b0, rd_pref}) - $signed({1'b0, rd_min});
  assign prod_mag = prod_r[PROD_W-1] ? -prod_r : prod_r;
  assign flex_add = prod_r[PROD_W-1] ? -$signed((WID_W+1)'(drsp.quot[SHORT_STEPS-1:0]))
                                     :  $signed((WID_W+1)'(drsp.quot[SHORT_STEPS-1:0]));
  assign flex_wid = $signed((WID_W+1)'(rd_min)) + flex_add;
  assign tail_wid = (WID_W+1)'(avail_r) - (WID_W+1)'(asum_r);

  cwd_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_pref (in_pref),
    .wr_min  (in_min),
    .rd_addr (idx_r),
    .rd_pref (rd_pref),
    .rd_min  (rd_min)
  );

  cwd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:   if (in_acc && in_tlast) state_nxt = S_SETUP;
      S_SETUP:  state_nxt = fit_all ? S_PDIV : S_RD;
      S_PDIV:   if (!drsp.busy) state_nxt = S_RD;
      S_RD:     state_nxt = S_MUL;
      S_MUL:    state_nxt = (mode_r == MODE_FLEX && !col_last) ? S_QSTART : S_OUT;
      S_QSTART: state_nxt = S_QWAIT;
      S_QWAIT:  if (!drsp.busy) state_nxt = S_OUT;
      S_OUT:    if (out_acc) state_nxt = col_last ? S_LOAD : S_RD;
      default:  state_nxt = S_LOAD;
    endcase
  end

  // Handshake and divider control
  always_comb begin
    in_tready     = state_r == S_LOAD;
    out_tvalid    = state_r == S_OUT;
    dreq.start    = (state_r == S_SETUP && fit_all) || state_r == S_QSTART;
    dreq.short_q  = state_r == S_QSTART;
    dreq.dividend = (state_r == S_QSTART) ? prod_mag[DVD_W-1:0]
                                          : DVD_W'(avail_r - AVAIL_W'(ptot_r));
    dreq.divisor  = (state_r == S_QSTART) ? tflex_r : DVS_W'(count_r);
  end

  // Datapath next values
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    ptot_nxt  = ptot_r;
    mtot_nxt  = mtot_r;
    avail_nxt = avail_r;
    idx_nxt   = idx_r;
    span_nxt  = span_r;
    tflex_nxt = tflex_r;
    per_nxt   = per_r;
    prem_nxt  = prem_r;
    prod_nxt  = prod_r;
    asum_nxt  = asum_r;
    oidx_nxt  = oidx_r;
    owid_nxt  = owid_r;
    olast_nxt = olast_r;
    case (state_r)
      S_LOAD: begin
        // accumulate one column word while the store has room, sample the width on the last one
        if (wr_en) begin
          count_nxt = count_r + 1'b1;
          ptot_nxt  = ptot_r + TOT_W'(in_pref);
          mtot_nxt  = mtot_r + TOT_W'(in_min);
        end
        if (in_acc && in_tlast) avail_nxt = in_avail;
      end
      S_SETUP: begin
        idx_nxt   = '0;
        asum_nxt  = '0;
        tflex_nxt = ptot_r - mtot_r;
        span_nxt  = avail_r - AVAIL_W'(mtot_r);
        if (fit_all) mode_nxt = MODE_FIT;
        else if (min_over) mode_nxt = MODE_MIN;
        else mode_nxt = MODE_FLEX;
      end
      S_PDIV: begin
        // hold the equal slack share and its leftover
        if (!drsp.busy) begin
          per_nxt  = drsp.quot;
          prem_nxt = drsp.rem[IDX_W-1:0];
        end
      end
      S_MUL: begin
        oidx_nxt  = COLIDX_W'(idx_r);
        olast_nxt = col_last;
        unique case (mode_r)
          MODE_FIT:  owid_nxt = WID_W'(rd_pref) + WID_W'(per_r)
                              + (col_last ? WID_W'(prem_r) : '0);
          MODE_MIN:  owid_nxt = WID_W'(rd_min);
          MODE_FLEX: begin
            owid_nxt = tail_wid[WID_W-1:0];
            prod_nxt = PROD_W'($signed({1'b0, span_r})) * PROD_W'(flex);
          end
          default:   owid_nxt = WID_W'(rd_min);
        endcase
      end
      S_QWAIT: begin
        if (!drsp.busy) begin
          owid_nxt = flex_wid[WID_W-1:0];
          asum_nxt = asum_r + TOT_W'(flex_wid[WID_W-1:0]);
        end
      end
      S_OUT: begin
        // advance to the next column, or drop the run state after the last word
        if (out_acc) begin
          if (col_last) begin
            count_nxt = '0;
            ptot_nxt  = '0;
            mtot_nxt  = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      ptot_r  <= '0;
      mtot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptot_r  <= ptot_nxt;
      mtot_r  <= mtot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    avail_r <= avail_nxt;
    idx_r   <= idx_nxt;
    span_r  <= span_nxt;
    tflex_r <= tflex_nxt;
    per_r   <= per_nxt;
    prem_r  <= prem_nxt;
    prod_r  <= prod_nxt;
    asum_r  <= asum_nxt;
    oidx_r  <= oidx_nxt;
    owid_r  <= owid_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tdata = {2'b00, owid_r, oidx_r};
  assign out_tlast = olast_r;

endmodule

/* test/tb_column_width_distributor.sv */
`timescale 1ns / 100ps

module tb_column_width_distributor;
  import cwd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [FIELD_W-1:0] pref;
    logic [FIELD_W-1:0] mn;
    logic [AVAIL_W-1:0] avail;
    logic               last;
  } column_word_t;

  typedef struct {
    logic [COLIDX_W-1:0] idx;
    logic [WID_W-1:0]    width;
    logic                last;
  } width_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // [11:0] pref_width, [23:12] min_width, [39:24] avail_width
  logic        in_tlast = 1'b0;  // last_column
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;  // [4:0] col_index, [21:5] col_width, [23:22] zero
  logic        out_tlast;  // last_result

  // Stimulus and expected widths
  column_word_t columns_pending[$];
  width_word_t  widths_due[$];

  // Predictor state: stored columns and running totals
  int          pref_mem[MAX_COLS];
  int          min_mem[MAX_COLS];
  int          col_count;
  longint      pref_sum;
  longint      min_sum;

  // Bookkeeping
  int          fail_count;
  int          words_total;
  int          words_taken;
  int          widths_checked;
  int          fit_runs, min_runs, flex_runs;
  int          cycle_count;
  int          hold_left;
  logic        hold_done;
  int          send_idle;
  int          recv_idle;
  column_word_t nxt_col;
  width_word_t  want;

  column_width_distributor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle rates by third of the run: sender light first, then receiver light, then none
  always_comb begin
    if (words_taken * 3 < words_total) begin
      send_idle = 10;
      recv_idle = 57;
    end else if (words_taken * 3 < words_total * 2) begin
      send_idle = 57;
      recv_idle = 10;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  // Queue one expected width word
  function automatic void post_width(int i, int n, longint w);
    width_word_t r;
    r.idx   = i[COLIDX_W-1:0];
    r.width = w[WID_W-1:0];
    r.last  = (i + 1 == n);
    widths_due.push_back(r);
  endfunction

  // Store one column; on the last column distribute the available width
  function automatic void load_column(logic [FIELD_W-1:0] pref, logic [FIELD_W-1:0] mn,
                                      logic [AVAIL_W-1:0] avail, logic last);
    longint a, slack, per, room, tflex, flex, add, assigned, w;
    int n;
    if (col_count < MAX_COLS) begin
      pref_mem[col_count] = pref;
      min_mem[col_count]  = mn;
      col_count++;
      pref_sum += pref;
      min_sum  += mn;
    end
    if (!last) return;
    n = col_count;
    a = avail;
    if (pref_sum <= a) begin
      // Preferred widths fit: spread the slack, remainder to the last column
      fit_runs++;
      slack = a - pref_sum;
      per   = slack / n;
      for (int i = 0; i < n; i++) begin
        w = pref_mem[i] + per;
        if (i + 1 == n) w += slack - per * n;
        post_width(i, n, w);
      end
    end else if (min_sum >= a) begin
      min_runs++;
      for (int i = 0; i < n; i++) post_width(i, n, min_mem[i]);
    end else begin
      // Scale room by flex; rounding leftover lands on the last column
      flex_runs++;
      room     = a - min_sum;
      tflex    = pref_sum - min_sum;
      assigned = 0;
      w        = 0;
      for (int i = 0; i < n; i++) begin
        flex = pref_mem[i] - min_mem[i];
        add  = (room * flex) / tflex;
        w    = min_mem[i] + add;
        assigned += w;
        if (i + 1 < n) post_width(i, n, w);
      end
      post_width(n - 1, n, w + (a - assigned));
    end
    col_count = 0;
    pref_sum  = 0;
    min_sum   = 0;
  endfunction

  // Width biased toward the field extremes
  function automatic logic [FIELD_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Driver: predict on each accepted word, then offer the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        load_column(in_tdata[11:0], in_tdata[23:12], in_tdata[39:24], in_tlast);
        words_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (columns_pending.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          nxt_col = columns_pending.pop_front();
          in_tdata  <= {nxt_col.avail, nxt_col.mn, nxt_col.pref};
          in_tlast  <= nxt_col.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted width word against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (widths_due.size() == 0) begin
          $error("unexpected width word: col_index %0d col_width %0d",
                 out_tdata[4:0], $signed(out_tdata[21:5]));
          fail_count++;
        end else begin
          want = widths_due.pop_front();
          widths_checked++;
          if (out_tdata[4:0] !== want.idx) begin
            $error("col_index: expected %0d, got %0d", want.idx, out_tdata[4:0]);
            fail_count++;
          end
          if (out_tdata[21:5] !== want.width) begin
            $error("col_width: expected %0d, got %0d", $signed(want.width),
                   $signed(out_tdata[21:5]));
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, out_tlast);
            fail_count++;
          end
          if (out_tdata[23:22] !== 2'b00) begin
            $error("tdata pad: expected 0, got %0d", out_tdata[23:22]);
            fail_count++;
          end
        end
      end
      // Hold off once for a long stretch so the block backs up into its input
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && words_taken >= 40) begin
        hold_done  <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic add_column(int pref, int mn, int avail, bit last);
    column_word_t c;
    c.pref  = pref[FIELD_W-1:0];
    c.mn    = mn[FIELD_W-1:0];
    c.avail = avail[AVAIL_W-1:0];
    c.last  = last;
    columns_pending.push_back(c);
  endtask

  initial begin
    int          rnd_words;
    int          tbl_no;
    int          n_cols;
    int unsigned p_tot, m_tot, hi;
    int          p_arr[40];
    int          m_arr[40];
    int          avail;

    fail_count = 0;
    words_taken = 0;
    widths_checked = 0;
    fit_runs = 0;
    min_runs = 0;
    flex_runs = 0;
    cycle_count = 0;
    hold_left = 0;
    hold_done = 1'b0;
    col_count = 0;
    pref_sum = 0;
    min_sum = 0;

    // Directed: single columns at the extremes
    add_column(0, 0, 0, 1);
    add_column(4095, 4095, 65535, 1);
    // Totals fit with a remainder for the last column
    add_column(100, 0, 1, 0);
    add_column(200, 50, 2, 0);
    add_column(300, 4095, 1000, 1);
    // Preferred total exactly equals the available width
    add_column(2000, 10, 0, 0);
    add_column(3000, 20, 5000, 1);
    // Minimums overflow, then minimums exactly meet the available width
    add_column(4095, 4095, 0, 0);
    add_column(4095, 4095, 100, 1);
    add_column(80, 50, 0, 0);
    add_column(90, 50, 100, 1);
    // Minimums above the available width, positive flex only
    add_column(1000, 0, 0, 0);
    add_column(500, 100, 0, 0);
    add_column(4095, 4000, 3000, 1);
    // In between with a column whose preferred width is below its minimum
    add_column(10, 4000, 65535, 0);
    add_column(4095, 0, 0, 0);
    add_column(3000, 100, 5000, 1);

    // Random tables: mostly short, a few that overrun the column store
    rnd_words = 0;
    tbl_no = 0;
    while (rnd_words < 100) begin
      if (tbl_no == 1) n_cols = 34;
      else if (tbl_no == 4) n_cols = MAX_COLS;
      else if ($urandom_range(0, 15) == 0) n_cols = $urandom_range(30, 35);
      else n_cols = $urandom_range(1, 8);
      p_tot = 0;
      m_tot = 0;
      for (int k = 0; k < n_cols; k++) begin
        p_arr[k] = pick_width();
        m_arr[k] = pick_width();
        if (k < MAX_COLS) begin
          p_tot += p_arr[k];
          m_tot += m_arr[k];
        end
      end
      // Aim the available width at one of the distribution cases
      case ($urandom_range(0, 3))
        0: avail = (p_tot <= 65535) ? $urandom_range(p_tot, 65535) : $urandom_range(0, 65535);
        1: avail = $urandom_range(0, (m_tot > 65535) ? 65535 : m_tot);
        2: begin
          if (m_tot < p_tot && m_tot < 65535) begin
            hi = (p_tot - 1 > 65535) ? 65535 : p_tot - 1;
            avail = $urandom_range(m_tot + 1, hi);
          end else begin
            avail = $urandom_range(0, 65535);
          end
        end
        default: avail = $urandom_range(0, 65535);
      endcase
      for (int k = 0; k < n_cols; k++) begin
        if (k + 1 == n_cols) add_column(p_arr[k], m_arr[k], avail, 1);
        else add_column(p_arr[k], m_arr[k], $urandom_range(0, 65535), 0);
      end
      rnd_words += n_cols;
      tbl_no++;
    end
    words_total = columns_pending.size();

    // Reset, then wait for every word to go in and every width to come out
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (columns_pending.size() > 0 || in_tvalid || widths_due.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d column words; checked %0d widths over %0d fit, %0d minimum, %0d flex runs",
             words_taken, widths_checked, fit_runs, min_runs, flex_runs);
    $display("Covered store overrun, exact-fit edges and one %0d-cycle output stall",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cwd_pkg.sv
rtl/cwd_store.sv
rtl/cwd_div.sv
rtl/column_width_distributor.sv
test/tb_column_width_distributor.sv
